### sv/gbf_pkg.sv
// Shared types and constants for the gray bilateral filter.
// No dependencies; gbf_front, gbf_back and gray_bilateral_filter import this package.
package gbf_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxR      = 7;
  localparam int unsigned LineRows  = 2 * MaxR + 1;
  localparam int unsigned LsDepth   = LineRows * MaxWidth;
  localparam int unsigned LsAddrW   = $clog2(LsDepth);
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned SlotW     = LsAddrW - ColW;
  localparam int unsigned SpDepth   = MaxR + 1;
  localparam int unsigned SpAddrW   = $clog2(SpDepth);
  localparam int unsigned RgDepth   = 256;
  localparam int unsigned WeightW   = 17;
  localparam logic [WeightW-1:0] OneQ16 = 17'd65536;

  // Input command codes
  localparam logic [1:0] CMD_PIXEL  = 2'd0;
  localparam logic [1:0] CMD_LOAD_S = 2'd1;
  localparam logic [1:0] CMD_LOAD_R = 2'd2;
  localparam logic [1:0] CMD_DRAIN  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  // Luma coefficients, Q0.16
  localparam logic [15:0] CoefB = 16'd4732;
  localparam logic [15:0] CoefG = 16'd46871;
  localparam logic [15:0] CoefR = 16'd13933;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_LOAD_S,
    OP_LOAD_R,
    OP_DRAIN
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         gray;
    logic [7:0]         idx;
    logic [WeightW-1:0] val;
  } q_item_t;

  typedef struct packed {
    logic [10:0] w;
    logic [12:0] h;
    logic [2:0]  r;
  } cfg_t;

endpackage

### sv/gbf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gbf_front.sv
// Front end: classifies input beats, converts colour to gray, queues them.
// Depends on gbf_pkg.
module gbf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       blue_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       table_index_i,
  input  logic [16:0]      table_value_i,
  output logic             q_valid_o,
  output gbf_pkg::q_item_t q_item_o,
  input  logic             q_pop_i
);
  import gbf_pkg::*;

  q_item_t     entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  q_item_t     item;
  logic        keep;
  logic        push;
  logic [23:0] luma;

  assign in_ready_o = (cnt_q != 2'd2);

  // Weighted colour sum
  assign luma = 24'(CoefB) * 24'(blue_i) + 24'(CoefG) * 24'(green_i) +
                24'(CoefR) * 24'(red_i);

  // Classify the beat
  always_comb begin
    item      = '0;
    item.gray = luma[23:16];
    item.idx  = table_index_i;
    item.val  = (table_value_i > OneQ16) ? OneQ16 : table_value_i;
    keep      = 1'b1;
    case (cmd_i)
      CMD_PIXEL:  item.op = OP_PIXEL;
      CMD_LOAD_S: begin
        item.op = OP_LOAD_S;
        keep    = (table_index_i <= 8'(MaxR));
      end
      CMD_LOAD_R: item.op = OP_LOAD_R;
      CMD_DRAIN:  item.op = OP_DRAIN;
      default:    item.op = OP_DRAIN;
    endcase
  end

  assign push = in_valid_i && in_ready_o && keep;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = entry_q[rd_ptr_q];

endmodule

### sv/gbf_back.sv
// Back end: line store, weight tables, window walk with a shared MAC,
// serial divider and the output register. Depends on gbf_pkg and gbf_ram.
module gbf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbf_pkg::cfg_t    cfg_i,
  input  logic             restart_i,
  input  logic             q_valid_i,
  input  gbf_pkg::q_item_t q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       filtered_pixel_o,
  output logic [11:0]      out_row_o,
  output logic [9:0]       out_col_o,
  output logic             last_of_run_o,
  output logic             end_of_frame_o
);
  import gbf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PIXW  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_CREAD = 4'd3;
  localparam logic [3:0] S_CWAIT = 4'd4;
  localparam logic [3:0] S_TAPS  = 4'd5;
  localparam logic [3:0] S_FLUSH = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_LAST  = 4'd9;

  logic [3:0] state_q, state_d;

  q_item_t item_q;
  logic [11:0] in_row_q, out_row_q;
  logic [9:0]  in_col_q, out_col_q;
  logic [SlotW-1:0] in_slot_q, out_slot_q, slot_q;
  logic in_done_q, out_done_q, drain_q;
  logic [2:0] k_q;

  logic signed [3:0]  dy_q, dx_q;
  logic signed [13:0] ty_q;
  logic [7:0]  c_q;
  logic        v1_q, v2_q, v3_q;
  logic [WeightW-1:0] s_q, wt_q;
  logic [7:0]  p1_q, p2_q;
  logic [31:0] num_q;
  logic [23:0] den_q;
  logic [31:0] rem_q, dsh_q;
  logic [7:0]  quo_q;
  logic [2:0]  dcnt_q;

  logic [7:0]  res_pix_q;
  logic [11:0] res_row_q;
  logic [9:0]  res_col_q;
  logic        res_eof_q;

  logic        out_valid_q;
  logic [7:0]  o_pix_q;
  logic [11:0] o_row_q;
  logic [9:0]  o_col_q;
  logic        o_last_q, o_eof_q;

  // Derived bounds
  logic [12:0] hm1, nr13, nr;
  logic [10:0] wm1, nc11, nc;
  logic        rdy;
  logic signed [3:0] r_s;
  logic        last_res, out_free, last_tap;

  assign hm1  = cfg_i.h - 13'd1;
  assign wm1  = cfg_i.w - 11'd1;
  assign r_s  = signed'({1'b0, cfg_i.r});
  assign nr13 = {1'b0, out_row_q} + 13'(cfg_i.r);
  assign nc11 = {1'b0, out_col_q} + 11'(cfg_i.r);
  assign nr   = (nr13 > hm1) ? hm1 : nr13;
  assign nc   = (nc11 > wm1) ? wm1 : nc11;

  // Window of the next result has fully arrived
  assign rdy = !out_done_q && (in_done_q || ({1'b0, in_row_q} > nr) ||
               ({1'b0, in_row_q} == nr && {1'b0, in_col_q} > nc));

  assign last_res = drain_q || (k_q == 3'd7) || !rdy;
  assign out_free = !out_valid_q || out_ready_i;
  assign last_tap = (dy_q == r_s) && (dx_q == r_s);

  // Tap column, clamped to the frame
  logic signed [11:0] tx;
  logic [9:0]  nx;
  logic [2:0]  adx, ady;
  assign tx  = signed'({2'b00, out_col_q}) + 12'(dx_q);
  assign nx  = tx[11] ? 10'd0 : ((tx[10:0] > wm1) ? wm1[9:0] : tx[9:0]);
  assign adx = dx_q[3] ? 3'(-dx_q) : dx_q[2:0];
  assign ady = dy_q[3] ? 3'(-dy_q) : dy_q[2:0];

  // First window row and its slot in the line store
  logic [4:0]  slot_tmp;
  logic [SlotW-1:0] slot0;
  logic signed [13:0] ty0;
  assign ty0      = signed'({2'b00, out_row_q}) - 14'(cfg_i.r);
  assign slot_tmp = {1'b0, out_slot_q} + 5'(LineRows) - 5'(cfg_i.r);
  assign slot0    = ty0[13] ? '0 :
                    ((slot_tmp >= 5'(LineRows)) ? SlotW'(slot_tmp - 5'(LineRows))
                                                : SlotW'(slot_tmp));

  // Memories
  logic             ls_we;
  logic [LsAddrW-1:0] ls_waddr, ls_raddr;
  logic [7:0]       ls_rdata;
  logic             sp_we, rg_we;
  logic [WeightW-1:0] sx_rdata, sy_rdata, rg_rdata;
  logic [7:0]       diff;

  assign ls_we    = (state_q == S_PIXW);
  assign ls_waddr = {in_slot_q, in_col_q};
  assign ls_raddr = (state_q == S_TAPS) ? {slot_q, nx} : {out_slot_q, out_col_q};
  assign sp_we    = (state_q == S_IDLE) && q_valid_i && (q_item_i.op == OP_LOAD_S);
  assign rg_we    = (state_q == S_IDLE) && q_valid_i && (q_item_i.op == OP_LOAD_R);
  assign diff     = (c_q > ls_rdata) ? (c_q - ls_rdata) : (ls_rdata - c_q);

  gbf_ram #(.Width(8), .Depth(LsDepth)) u_line_store (
    .clk_i, .we_i(ls_we), .waddr_i(ls_waddr), .wdata_i(item_q.gray),
    .raddr_i(ls_raddr), .rdata_o(ls_rdata)
  );

  gbf_ram #(.Width(WeightW), .Depth(SpDepth)) u_spatial_x (
    .clk_i, .we_i(sp_we), .waddr_i(q_item_i.idx[SpAddrW-1:0]), .wdata_i(q_item_i.val),
    .raddr_i(adx), .rdata_o(sx_rdata)
  );

  gbf_ram #(.Width(WeightW), .Depth(SpDepth)) u_spatial_y (
    .clk_i, .we_i(sp_we), .waddr_i(q_item_i.idx[SpAddrW-1:0]), .wdata_i(q_item_i.val),
    .raddr_i(ady), .rdata_o(sy_rdata)
  );

  gbf_ram #(.Width(WeightW), .Depth(RgDepth)) u_range (
    .clk_i, .we_i(rg_we), .waddr_i(q_item_i.idx), .wdata_i(q_item_i.val),
    .raddr_i(diff), .rdata_o(rg_rdata)
  );

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.op)
            OP_PIXEL: state_d = S_PIXW;
            OP_DRAIN: state_d = S_CHECK;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_PIXW:  state_d = S_CHECK;
      S_CHECK: state_d = rdy ? S_CREAD : S_IDLE;
      S_CREAD: state_d = S_CWAIT;
      S_CWAIT: state_d = S_TAPS;
      S_TAPS:  state_d = last_tap ? S_FLUSH : S_TAPS;
      S_FLUSH: state_d = (!v1_q && !v2_q && !v3_q) ? S_DIV : S_FLUSH;
      S_DIV:   state_d = (dcnt_q == 3'd0) ? S_UPD : S_DIV;
      S_UPD:   state_d = S_LAST;
      S_LAST: begin
        if (out_free) begin
          state_d = last_res ? S_IDLE : S_CREAD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      in_done_q  <= 1'b0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      out_done_q <= 1'b0;
      drain_q    <= 1'b0;
      k_q        <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == S_TAPS);
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (restart_i ||
          (state_q == S_IDLE && q_valid_i && q_item_i.op == OP_PIXEL && in_done_q)) begin
        // Restart the frame
        in_row_q   <= '0;
        in_col_q   <= '0;
        in_slot_q  <= '0;
        in_done_q  <= 1'b0;
        out_row_q  <= '0;
        out_col_q  <= '0;
        out_slot_q <= '0;
        out_done_q <= 1'b0;
      end else begin
        case (state_q)
          S_PIXW: begin
            // Advance the input position
            if ({1'b0, in_col_q} + 11'd1 >= cfg_i.w) begin
              in_col_q <= '0;
              if ({1'b0, in_row_q} + 13'd1 >= cfg_i.h) begin
                in_row_q  <= '0;
                in_slot_q <= '0;
                in_done_q <= 1'b1;
              end else begin
                in_row_q  <= in_row_q + 12'd1;
                in_slot_q <= (in_slot_q == SlotW'(LineRows - 1)) ? '0 : in_slot_q + 1'b1;
              end
            end else begin
              in_col_q <= in_col_q + 10'd1;
            end
          end
          S_UPD: begin
            // Advance the output position
            if (res_eof_q) begin
              out_done_q <= 1'b1;
              out_row_q  <= '0;
              out_col_q  <= '0;
              out_slot_q <= '0;
            end else if ({1'b0, out_col_q} + 11'd1 >= cfg_i.w) begin
              out_col_q  <= '0;
              out_row_q  <= out_row_q + 12'd1;
              out_slot_q <= (out_slot_q == SlotW'(LineRows - 1)) ? '0 : out_slot_q + 1'b1;
            end else begin
              out_col_q <= out_col_q + 10'd1;
            end
          end
          default: ;
        endcase
      end
      if (state_q == S_IDLE && q_valid_i) begin
        drain_q <= (q_item_i.op == OP_DRAIN);
        k_q     <= '0;
      end
      // Load a new output beat, or drop the one taken
      if (state_q == S_LAST && out_free) begin
        out_valid_q <= 1'b1;
        k_q         <= k_q + 3'd1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: window walk, MAC pipeline, divider, result registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) begin
      item_q <= q_item_i;
    end
    // Weight and accumulate
    s_q  <= WeightW'((33'(sy_rdata) * 33'(sx_rdata)) >> 16);
    p1_q <= ls_rdata;
    wt_q <= WeightW'((34'(s_q) * 34'(rg_rdata)) >> 16);
    p2_q <= p1_q;
    if (v3_q) begin
      num_q <= num_q + 32'(wt_q) * 32'(p2_q);
      den_q <= den_q + 24'(wt_q);
    end
    case (state_q)
      S_CREAD: begin
        dy_q   <= -r_s;
        dx_q   <= -r_s;
        ty_q   <= ty0;
        slot_q <= slot0;
        num_q  <= '0;
        den_q  <= '0;
      end
      S_CWAIT: c_q <= ls_rdata;
      S_TAPS: begin
        if (dx_q == r_s) begin
          dx_q <= -r_s;
          dy_q <= dy_q + 4'sd1;
          ty_q <= ty_q + 14'sd1;
          if (!ty_q[13] && ty_q[12:0] < hm1) begin
            slot_q <= (slot_q == SlotW'(LineRows - 1)) ? '0 : slot_q + 1'b1;
          end
        end else begin
          dx_q <= dx_q + 4'sd1;
        end
      end
      S_FLUSH: begin
        rem_q  <= num_q;
        dsh_q  <= {1'b0, den_q, 7'd0};
        quo_q  <= '0;
        dcnt_q <= 3'd7;
      end
      S_DIV: begin
        // One quotient bit per cycle
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[6:0], 1'b1};
        end else begin
          quo_q <= {quo_q[6:0], 1'b0};
        end
        dsh_q  <= dsh_q >> 1;
        dcnt_q <= dcnt_q - 3'd1;
      end
      S_UPD: begin
        res_pix_q <= (den_q == '0) ? c_q : quo_q;
        res_row_q <= out_row_q;
        res_col_q <= out_col_q;
      end
      S_LAST: begin
        if (out_free) begin
          o_pix_q  <= res_pix_q;
          o_row_q  <= res_row_q;
          o_col_q  <= res_col_q;
          o_eof_q  <= res_eof_q;
          o_last_q <= last_res;
        end
      end
      default: ;
    endcase
    if (state_q == S_DIV) begin
      res_eof_q <= ({1'b0, out_row_q} == hm1) && ({1'b0, out_col_q} == wm1);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_pixel_o = o_pix_q;
  assign out_row_o        = o_row_q;
  assign out_col_o        = o_col_q;
  assign last_of_run_o    = o_last_q;
  assign end_of_frame_o   = o_eof_q;

endmodule

### sv/gray_bilateral_filter.sv
// Gray bilateral filter top level: configuration registers, front end, back end.
// Each result walks its (2r+1)^2 window taps, one tap per cycle through the
// shared multiply-accumulate, then a pipeline drain and eight divider steps.
// Table loads are taken while the back end is idle; drain beats check for a ready
// window, and pixel beats write the line store first. Reset is asynchronous, active
// low; it clears control state and restores the register defaults (width 1024,
// height 768, radius 3). Depends on gbf_pkg, gbf_front, gbf_back.
module gray_bilateral_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  table_index_i,
  input  logic [16:0] table_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  filtered_pixel_o,
  output logic [11:0] out_row_o,
  output logic [9:0]  out_col_o,
  output logic        last_of_run_o,
  output logic        end_of_frame_o
);
  import gbf_pkg::*;

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [2:0]  radius_q;
  logic        restart;
  cfg_t        cfg;
  logic        q_valid, q_pop;
  q_item_t     q_item;

  assign cfg_ready_o = 1'b1;
  assign restart     = cfg_valid_i && (cfg_index_i <= REG_RADIUS);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 13'd768;
      radius_q <= 3'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i[10:0];
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_RADIUS: radius_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported frame
  always_comb begin
    cfg.w = (width_q == '0) ? 11'd1 :
            ((width_q > 11'(MaxWidth)) ? 11'(MaxWidth) : width_q);
    cfg.h = (height_q == '0) ? 13'd1 : ((height_q > 13'd4096) ? 13'd4096 : height_q);
    cfg.r = radius_q;
  end

  gbf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .blue_i, .green_i, .red_i,
    .table_index_i, .table_value_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  gbf_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .restart_i(restart),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .filtered_pixel_o, .out_row_o, .out_col_o,
    .last_of_run_o, .end_of_frame_o
  );

endmodule
